>>> sv/ccfs_pkg.sv
package ccfs_pkg;

   localparam int FRAME_DATA_BYTES = 7;
   localparam int FILL_W = 3;
   localparam int BUF_W = 56;

   typedef enum logic [1:0] {
      POS_ADDRESS,
      POS_FUNCTION,
      POS_DATA
   } pos_state_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       is_last;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] frame_id;
      logic [3:0]  frame_length;
      logic [63:0] frame_payload;
      logic        final_frame;
   } rsp_payload_type;

endpackage

>>> sv/can_command_frame_segmenter.sv
// A frame closed by a data byte goes to the two-entry output stage: to the result
// register, or to the skid register if the result register holds an untaken frame.
// One request byte per cycle while req_ready is high; the skid register keeps
// req_ready high while one frame waits; it drops only when both entries hold frames.
// Reset (synchronous, active high) clears the command state and both output entries.
module can_command_frame_segmenter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ccfs_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ccfs_pkg::rsp_payload_type rsp_payload
);
   import ccfs_pkg::*;

   pos_state_type         state_ff, state_in;
   logic [7:0]            address_ff, address_in;
   logic [7:0]            function_ff, function_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [7:0]            index_ff, index_in;
   logic [BUF_W-1:0]      buffer_ff, buffer_in;

   logic                  out_valid_ff, out_valid_in;
   rsp_payload_type       out_data_ff, out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   rsp_payload_type       skid_data_ff, skid_data_in;

   logic                  accept;
   logic                  take;
   logic                  emit;
   logic                  full;
   logic [FILL_W:0]       fill_inc;
   logic [BUF_W-1:0]      buffer_merged;
   rsp_payload_type       frame;

   assign accept    = req_valid && req_ready;
   assign take      = out_valid_ff && rsp_ready;
   assign req_ready = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         unique case (state_ff)
            POS_ADDRESS:  state_in = req_payload.is_last ? POS_ADDRESS : POS_FUNCTION;
            POS_FUNCTION: state_in = req_payload.is_last ? POS_ADDRESS : POS_DATA;
            POS_DATA:     state_in = req_payload.is_last ? POS_ADDRESS : POS_DATA;
            default:      state_in = POS_ADDRESS;
         endcase
      end
   end

   always_comb begin
      fill_inc = {1'b0, fill_ff} + {{FILL_W{1'b0}}, 1'b1};
      full     = fill_inc >= (FILL_W + 1)'(FRAME_DATA_BYTES);
      buffer_merged = buffer_ff;
      for (int k = 0; k < FRAME_DATA_BYTES; k++) begin
         if (fill_ff == FILL_W'(k)) begin
            buffer_merged[8*k +: 8] = req_payload.byte_value;
         end
      end
      frame.frame_id      = {address_ff, index_ff};
      frame.frame_length  = 4'(fill_inc) + 4'd1;
      frame.frame_payload = {buffer_merged, function_ff};
      frame.final_frame   = req_payload.is_last;

      address_in  = address_ff;
      function_in = function_ff;
      fill_in     = fill_ff;
      index_in    = index_ff;
      buffer_in   = buffer_ff;
      emit        = 1'b0;
      if (accept) begin
         unique case (state_ff)
            POS_ADDRESS: begin
               address_in = req_payload.byte_value;
            end
            POS_FUNCTION: begin
               function_in = req_payload.byte_value;
            end
            POS_DATA: begin
               emit = full || req_payload.is_last;
               if (emit) begin
                  fill_in   = '0;
                  buffer_in = '0;
                  index_in  = index_ff + 8'd1;
               end else begin
                  fill_in   = fill_inc[FILL_W-1:0];
                  buffer_in = buffer_merged;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
         if (req_payload.is_last) begin
            address_in  = '0;
            function_in = '0;
            fill_in     = '0;
            index_in    = '0;
            buffer_in   = '0;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = emit;
            out_data_in  = frame;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_data_in  = frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= POS_ADDRESS;
         address_ff    <= '0;
         function_ff   <= '0;
         fill_ff       <= '0;
         index_ff      <= '0;
         buffer_ff     <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         address_ff    <= address_in;
         function_ff   <= function_in;
         fill_ff       <= fill_in;
         index_ff      <= index_in;
         buffer_ff     <= buffer_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTHESIS
   skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");

   fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff < FILL_W'(FRAME_DATA_BYTES))
      else $error("fill count reached frame size");

   clean_outside_data: assert property (@(posedge clock) disable iff (reset)
      state_ff != POS_DATA |-> (fill_ff == '0 && index_ff == '0 && buffer_ff == '0))
      else $error("frame state not cleared outside data phase");

   last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.is_last |=> state_ff == POS_ADDRESS)
      else $error("command did not restart after last byte");
`endif

endmodule

>>> sim/can_command_frame_segmenter_tb.sv
module can_command_frame_segmenter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccfs_pkg::*;

   localparam int PRESSURE_AT = 600;
   localparam int PRESSURE_CYCLES = 300;
   localparam int QUIET_FROM = 900;
   localparam int QUIET_TO = 1300;
   localparam int RANDOM_ITEMS = 1625;
   localparam int DRAIN_CYCLES = 16;

   class frame_scoreboard;
      rsp_payload_type pending_frames[$];
      int              mismatches;
      pos_state_type   cmd_pos;
      logic [7:0]      addr_byte;
      logic [7:0]      func_byte;
      logic [2:0]      fill;
      logic [7:0]      frame_idx;
      logic [55:0]     data_bytes;

      function new();
         mismatches = 0;
         clear_command();
      endfunction

      function void clear_command();
         cmd_pos = POS_ADDRESS;
         addr_byte = '0;
         func_byte = '0;
         fill = '0;
         frame_idx = '0;
         data_bytes = '0;
      endfunction

      task flag_mismatch(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      function void note_request(input req_payload_type r);
         rsp_payload_type f;
         case (cmd_pos)
            POS_ADDRESS: begin
               addr_byte = r.byte_value;
               cmd_pos = POS_FUNCTION;
               if (r.is_last) clear_command();
            end
            POS_FUNCTION: begin
               func_byte = r.byte_value;
               cmd_pos = POS_DATA;
               if (r.is_last) clear_command();
            end
            default: begin
               data_bytes[fill * 8 +: 8] = r.byte_value;
               fill = fill + 3'd1;
               if (fill == FRAME_DATA_BYTES || r.is_last) begin
                  f.frame_id = {addr_byte, frame_idx};
                  f.frame_length = {1'b0, fill} + 4'd1;
                  f.frame_payload = {data_bytes, func_byte};
                  f.final_frame = r.is_last;
                  pending_frames.push_back(f);
                  if (r.is_last) begin
                     clear_command();
                  end else begin
                     frame_idx = frame_idx + 8'd1;
                     fill = '0;
                     data_bytes = '0;
                  end
               end
            end
         endcase
      endfunction

      task check_frame(input rsp_payload_type got);
         rsp_payload_type want;
         if (pending_frames.size() == 0) begin
            flag_mismatch($sformatf("unexpected frame id %h", got.frame_id));
         end else begin
            want = pending_frames.pop_front();
            if (got.frame_id !== want.frame_id)
               flag_mismatch($sformatf("frame_id %h, want %h", got.frame_id, want.frame_id));
            if (got.frame_length !== want.frame_length)
               flag_mismatch($sformatf("frame_length %0d, want %0d",
                                       got.frame_length, want.frame_length));
            if (got.frame_payload !== want.frame_payload)
               flag_mismatch($sformatf("frame_payload %h, want %h",
                                       got.frame_payload, want.frame_payload));
            if (got.final_frame !== want.final_frame)
               flag_mismatch($sformatf("final_frame %b, want %b",
                                       got.final_frame, want.final_frame));
         end
      endtask
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   frame_scoreboard sb = new();
   int              requests_accepted = 0;
   bit              quiet = 1'b0;

   can_command_frame_segmenter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("status: fail");
      $finish;
   end

   task send_request(input logic [7:0] value, input logic last);
      req_payload_type r;
      int gap;
      r.byte_value = value;
      r.is_last = last;
      gap = (!quiet && $urandom_range(0, 99) < 10) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      requests_accepted++;
      quiet = requests_accepted >= QUIET_FROM && requests_accepted < QUIET_TO;
   endtask

   task send_command(input int len, input bit extremes);
      logic [7:0] value;
      for (int i = 0; i < len; i++) begin
         value = extremes ? ((i % 2) ? 8'h00 : 8'hFF) : 8'($urandom);
         send_request(value, i == len - 1);
      end
   endtask

   initial begin
      int len;
      int pick;
      int sent;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(1, 1'b1);
      send_command(2, 1'b1);
      send_command(3, 1'b1);
      send_command(2 + FRAME_DATA_BYTES, 1'b1);
      send_command(3 + FRAME_DATA_BYTES, 1'b1);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 10)
            len = $urandom_range(1, 2);
         else if (pick < 30)
            len = 2 + FRAME_DATA_BYTES * $urandom_range(1, 4);
         else
            len = $urandom_range(3, 40);
         send_command(len, 1'b0);
         sent += len;
      end
      req_valid <= 1'b0;

      while (sb.pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      int hold;
      bit held;
      hold = 0;
      held = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_valid && rsp_ready) sb.check_frame(rsp_payload);
         if (!held && requests_accepted >= PRESSURE_AT) begin
            held = 1'b1;
            hold = PRESSURE_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || $urandom_range(0, 99) >= 10;
         end
         @(posedge clock);
      end
   end

endmodule

>>> filelist.f
sv/ccfs_pkg.sv
sv/can_command_frame_segmenter.sv
sim/can_command_frame_segmenter_tb.sv
